// ===== design/flog2_pkg.sv =====
// Shared types, constants and status codes for the single-precision log2 block.
// No dependencies.
package flog2_pkg;

  localparam int FRAC_BITS = 30;
  localparam int AW = FRAC_BITS + 8;
  localparam int PW = $clog2(AW);

  typedef enum logic [1:0] {
    ST_NORMAL  = 2'd0,
    ST_INVALID = 2'd1,
    ST_ZERO    = 2'd2,
    ST_EXACT   = 2'd3
  } status_e;

  localparam logic [31:0] QNAN_NEG = 32'hFFC00000;
  localparam logic [31:0] QNAN_POS = 32'h7FC00000;
  localparam logic [31:0] NEG_INF  = 32'hFF800000;
  localparam logic [31:0] POS_INF  = 32'h7F800000;
  localparam logic [31:0] ONE_BITS = 32'h3F800000;

  localparam logic [31:0] TBL_IN  [5] = '{32'h3F800000, 32'h40000000, 32'h402DF854,
                                          32'h40490FDB, 32'h40C90FDB};
  localparam logic [31:0] TBL_OUT [5] = '{32'h00000000, 32'h3F800000, 32'h3FB8AA3B,
                                          32'h3FD3643A, 32'h4029B21D};

  typedef struct packed {
    logic               special;
    logic [31:0]        res;
    status_e            st;
    logic signed [8:0]  e;
    logic [23:0]        m;
  } item_t;

  typedef struct packed {
    logic                  valid;
    logic                  special;
    logic [31:0]           res;
    status_e               st;
    logic signed [8:0]     e;
    logic [62:0]           y;
    logic [FRAC_BITS-1:0]  f;
  } sq_t;

endpackage

// ===== design/flog2_front.sv =====
// Front end: classifies an operand into a special result or exponent/mantissa.
// Depends on flog2_pkg.
module flog2_front (
  input  logic [31:0]          operand_bits_i,
  output flog2_pkg::item_t     item_o
);

  logic [7:0]  ex;
  logic [22:0] fr;
  logic [4:0]  pos;
  logic [4:0]  shamt;
  logic        hit;
  logic [31:0] tres;

  assign ex = operand_bits_i[30:23];
  assign fr = operand_bits_i[22:0];

  always_comb begin
    pos = '0;
    for (int i = 0; i < 23; i++) begin
      if (fr[i]) pos = 5'(i);
    end
    shamt = 5'd23 - pos;
    hit  = 1'b0;
    tres = '0;
    for (int i = 0; i < 5; i++) begin
      if (operand_bits_i == flog2_pkg::TBL_IN[i]) begin
        hit  = 1'b1;
        tres = flog2_pkg::TBL_OUT[i];
      end
    end
  end

  always_comb begin
    item_o.special = 1'b1;
    item_o.res     = '0;
    item_o.st      = flog2_pkg::ST_NORMAL;
    item_o.e       = '0;
    item_o.m       = '0;
    if (ex == 8'hFF && fr != '0) begin
      item_o.res = operand_bits_i | 32'h00400000;
      item_o.st  = flog2_pkg::ST_INVALID;
    end else if (operand_bits_i[31]) begin
      item_o.res = ({1'b0, operand_bits_i[30:0]} < flog2_pkg::ONE_BITS) ?
                   flog2_pkg::QNAN_NEG : flog2_pkg::QNAN_POS;
      item_o.st  = flog2_pkg::ST_INVALID;
    end else if (operand_bits_i == '0) begin
      item_o.res = flog2_pkg::NEG_INF;
      item_o.st  = flog2_pkg::ST_ZERO;
    end else if (operand_bits_i == flog2_pkg::POS_INF) begin
      item_o.res = flog2_pkg::POS_INF;
    end else if (hit) begin
      item_o.res = tres;
      item_o.st  = flog2_pkg::ST_EXACT;
    end else begin
      item_o.special = 1'b0;
      if (ex == '0) begin
        item_o.e = -9'sd126 - $signed({4'd0, shamt});
        item_o.m = {1'b0, fr} << shamt;
      end else begin
        item_o.e = $signed({1'b0, ex}) - 9'sd127;
        item_o.m = {1'b1, fr};
      end
    end
  end

endmodule

// ===== design/flog2_queue.sv =====
// Two-entry request queue between front end and squaring pipeline.
// Depends on flog2_pkg.
module flog2_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  flog2_pkg::item_t item_i,
  input  logic             pop_i,
  output flog2_pkg::item_t item_o,
  output logic             empty_o,
  output logic             full_o
);

  flog2_pkg::item_t mem_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;

  assign empty_o = (cnt_q == 2'd0);
  assign full_o  = (cnt_q == 2'd2);
  assign item_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= item_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) wr_q <= ~wr_q;
      if (pop_i)  rd_q <= ~rd_q;
      cnt_q <= cnt_q + 2'(push_i) - 2'(pop_i);
    end
  end

endmodule

// ===== design/flog2_sqr_stage.sv =====
// One squaring iteration in two registered steps: partial products, then sum and bit decision.
// Depends on flog2_pkg.
module flog2_sqr_stage (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  flog2_pkg::sq_t s_i,
  output flog2_pkg::sq_t s_o
);

  flog2_pkg::sq_t mid_q, out_q;
  logic         mid_vld_q, out_vld_q;
  logic [63:0]  p00_q;
  logic [62:0]  p01_q;
  logic [61:0]  p11_q;
  logic [125:0] sq;
  logic [63:0]  q;
  flog2_pkg::sq_t out_d;

  always_comb begin
    sq = {p11_q, 64'd0} + {30'd0, p01_q, 33'd0} + {62'd0, p00_q};
    q  = sq[125:62];
    out_d   = mid_q;
    out_d.f = {mid_q.f[flog2_pkg::FRAC_BITS-2:0], q[63]};
    out_d.y = q[63] ? q[63:1] : q[62:0];
  end

  always_ff @(posedge clk_i) begin
    p00_q <= 64'(s_i.y[31:0]) * 64'(s_i.y[31:0]);
    p01_q <= 63'(s_i.y[31:0]) * 63'(s_i.y[62:32]);
    p11_q <= 62'(s_i.y[62:32]) * 62'(s_i.y[62:32]);
    mid_q <= s_i;
    out_q <= out_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mid_vld_q <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      mid_vld_q <= s_i.valid;
      out_vld_q <= mid_vld_q;
    end
  end

  always_comb begin
    s_o       = out_q;
    s_o.valid = out_vld_q;
  end

endmodule

// ===== design/flog2_back.sv =====
// Back end: squaring pipeline, then fixed-point to single conversion with RNE.
// Depends on flog2_pkg, flog2_sqr_stage.
module flog2_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             go_i,
  input  flog2_pkg::item_t item_i,
  output logic             valid_o,
  output logic [31:0]      result_bits_o,
  output logic [1:0]       status_o
);

  localparam int FB = flog2_pkg::FRAC_BITS;
  localparam int AW = flog2_pkg::AW;
  localparam int PW = flog2_pkg::PW;

  flog2_pkg::sq_t chain [FB+1];

  assign chain[0].valid   = go_i;
  assign chain[0].special = item_i.special;
  assign chain[0].res     = item_i.res;
  assign chain[0].st      = item_i.st;
  assign chain[0].e       = item_i.e;
  assign chain[0].y       = {item_i.m, 39'd0};
  assign chain[0].f       = '0;

  for (genvar i = 0; i < FB; i++) begin : g_sq
    flog2_sqr_stage u_stage (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .s_i    (chain[i]),
      .s_o    (chain[i+1])
    );
  end

  flog2_pkg::sq_t  last;
  logic [AW:0]     v;
  assign last = chain[FB];
  assign v    = {last.e, last.f};

  // stage A: magnitude
  logic a_vld_q, a_spc_q, a_neg_q;
  logic [31:0] a_res_q;
  flog2_pkg::status_e a_st_q;
  logic [AW-1:0] a_mag_q;

  // stage B: normalize
  logic b_vld_q, b_spc_q, b_neg_q, b_zero_q;
  logic [31:0] b_res_q;
  flog2_pkg::status_e b_st_q;
  logic [AW-1:0] b_n_q;
  logic [PW-1:0] b_p_q;

  logic [PW-1:0] p_d;
  logic [AW:0]   vneg;

  always_comb begin
    p_d = '0;
    for (int i = 0; i < AW; i++) begin
      if (a_mag_q[i]) p_d = PW'(i);
    end
  end

  assign vneg = -v;

  always_ff @(posedge clk_i) begin
    a_spc_q <= last.special;
    a_res_q <= last.res;
    a_st_q  <= last.st;
    a_neg_q <= v[AW];
    a_mag_q <= v[AW] ? vneg[AW-1:0] : v[AW-1:0];
    b_spc_q  <= a_spc_q;
    b_res_q  <= a_res_q;
    b_st_q   <= a_st_q;
    b_neg_q  <= a_neg_q;
    b_zero_q <= (a_mag_q == '0);
    b_n_q    <= a_mag_q << (PW'(AW - 1) - p_d);
    b_p_q    <= p_d;
  end

  logic          guard, sticky, rnd;
  logic [24:0]   mant25;
  logic [22:0]   frac;
  logic [PW:0]   pe;
  logic [7:0]    bexp;
  logic [31:0]   res_d;

  always_comb begin
    guard  = b_n_q[AW-25];
    sticky = |b_n_q[AW-26:0];
    rnd    = guard & (sticky | b_n_q[AW-24]);
    mant25 = {1'b0, b_n_q[AW-1 -: 24]} + 25'(rnd);
    if (mant25[24]) begin
      frac = mant25[23:1];
      pe   = {1'b0, b_p_q} + 1'b1;
    end else begin
      frac = mant25[22:0];
      pe   = {1'b0, b_p_q};
    end
    bexp = 8'(32'(pe) + 32'd127 - 32'(FB));
    if (b_spc_q) res_d = b_res_q;
    else if (b_zero_q) res_d = '0;
    else res_d = {b_neg_q, bexp, frac};
  end

  always_ff @(posedge clk_i) begin
    result_bits_o <= res_d;
    status_o      <= b_st_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
      b_vld_q <= 1'b0;
      valid_o <= 1'b0;
    end else begin
      a_vld_q <= last.valid;
      b_vld_q <= a_vld_q;
      valid_o <= b_vld_q;
    end
  end

endmodule

// ===== design/float_binary_logarithm.sv =====
// Top level of the single-precision base-2 logarithm block.
// Depends on flog2_pkg, flog2_front, flog2_queue, flog2_back.
//
// Usage:
//   Request channel: drive operand_bits_i and raise start_i; the request is
//   taken at a rising edge where start_i is high and busy_o is low.
//   Result channel: valid_o pulses for one cycle with result_bits_o and
//   status_o (0 normal, 1 invalid, 2 zero input, 3 exact table value).
//   The receiver cannot stall; results arrive in request order.
// Timing:
//   One request per cycle sustained. The request is registered in the queue,
//   then passes each squaring stage (partial products of the low 32 and high
//   31 bits registered, then the sum and bit decision registered), then the
//   magnitude and normalization registers, and rounding into the output
//   register.
//   The back end drains the queue every cycle, so busy_o stays low.
// Reset:
//   rst_ni clears the queue and all valid flags; no results are pending.
module float_binary_logarithm (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [31:0] operand_bits_i,
  output logic        valid_o,
  output logic [31:0] result_bits_o,
  output logic [1:0]  status_o
);

  flog2_pkg::item_t front_item, head_item;
  logic push, pop, empty, full;

  flog2_front u_front (
    .operand_bits_i (operand_bits_i),
    .item_o         (front_item)
  );

  assign push   = start_i & ~full;
  assign pop    = ~empty;
  assign busy_o = full;

  flog2_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (front_item),
    .pop_i   (pop),
    .item_o  (head_item),
    .empty_o (empty),
    .full_o  (full)
  );

  flog2_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .go_i          (pop),
    .item_i        (head_item),
    .valid_o       (valid_o),
    .result_bits_o (result_bits_o),
    .status_o      (status_o)
  );

  a_never_busy: assert property (@(posedge clk_i) disable iff (!rst_ni) !busy_o)
    else $error("queue filled up");
  a_zero_res: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && status_o == flog2_pkg::ST_ZERO |-> result_bits_o == flog2_pkg::NEG_INF)
    else $error("zero input result wrong");
  a_invalid_nan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && status_o == flog2_pkg::ST_INVALID |-> result_bits_o[30:22] == 9'h1FF)
    else $error("invalid result not quiet NaN");

endmodule

// ===== dv/float_binary_logarithm_checker.sv =====
// Checker for the single-precision log2 block: watches requests and results,
// predicts log2 bits and status, and counts mismatches. Depends on flog2_pkg.
`timescale 1ns / 100ps
module float_binary_logarithm_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic        busy_o,
  input  logic [31:0] operand_bits_i,
  input  logic        valid_o,
  input  logic [31:0] result_bits_o,
  input  logic [1:0]  status_o,
  output int          fail_count_o,
  output int          pending_o
);

  typedef struct {
    logic [31:0]        bits;
    flog2_pkg::status_e st;
  } log2_result_t;

  log2_result_t expected_logs[$];

  assign pending_o = expected_logs.size();

  function automatic logic [31:0] fixed_to_float(longint signed v);
    logic [63:0] a;
    logic [63:0] rem, half, mant;
    logic [31:0] sgn;
    int p, r;
    int bexp;
    sgn = 0;
    p = 0;
    if (v == 0) return 32'h0;
    if (v < 0) begin
      sgn = 32'h80000000;
      a = -v;
    end else begin
      a = v;
    end
    for (int i = 0; i < 64; i++) if (a[i]) p = i;
    if (p <= 23) begin
      mant = a << (23 - p);
    end else begin
      r = p - 23;
      rem = a & ((64'd1 << r) - 1);
      half = 64'd1 << (r - 1);
      mant = a >> r;
      if (rem > half || (rem == half && mant[0])) mant++;
      if (mant[24]) begin
        mant = mant >> 1;
        p++;
      end
    end
    bexp = p - flog2_pkg::FRAC_BITS + 127;
    return sgn | (32'(bexp) << 23) | (mant[31:0] & 32'h7FFFFF);
  endfunction

  function automatic log2_result_t predict_log2(logic [31:0] x);
    log2_result_t r;
    logic [7:0] ex;
    logic [22:0] fr;
    logic [23:0] m24;
    logic [63:0] y;
    logic [127:0] sq;
    logic [63:0] fbits;
    int e;
    ex = x[30:23];
    fr = x[22:0];
    r.st = flog2_pkg::ST_NORMAL;
    r.bits = 0;
    if (ex == 8'hFF && fr != 0) begin
      r.bits = x | 32'h00400000;
      r.st = flog2_pkg::ST_INVALID;
    end else if (x[31]) begin
      r.bits = (x[30:0] < 31'h3F800000) ? flog2_pkg::QNAN_NEG : flog2_pkg::QNAN_POS;
      r.st = flog2_pkg::ST_INVALID;
    end else if (x == 0) begin
      r.bits = flog2_pkg::NEG_INF;
      r.st = flog2_pkg::ST_ZERO;
    end else if (x == flog2_pkg::POS_INF) begin
      r.bits = flog2_pkg::POS_INF;
    end else begin
      for (int i = 0; i < 5; i++)
        if (x == flog2_pkg::TBL_IN[i]) begin
          r.bits = flog2_pkg::TBL_OUT[i];
          r.st = flog2_pkg::ST_EXACT;
        end
      if (r.st != flog2_pkg::ST_EXACT) begin
        if (ex == 0) begin
          e = -126;
          m24 = {1'b0, fr};
          while (!m24[23]) begin
            m24 = m24 << 1;
            e--;
          end
        end else begin
          e = int'(ex) - 127;
          m24 = {1'b1, fr};
        end
        y = 64'(m24) << 39;
        fbits = 0;
        for (int i = 0; i < flog2_pkg::FRAC_BITS; i++) begin
          sq = 128'(y) * 128'(y);
          y = sq[125:62];
          fbits = fbits << 1;
          if (y[63]) begin
            fbits[0] = 1'b1;
            y = y >> 1;
          end
        end
        r.bits = fixed_to_float(longint'(e) * (longint'(1) << flog2_pkg::FRAC_BITS) +
                                longint'(fbits));
      end
    end
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("%0t mismatch %s: got %h expected %h", $time, what, got, want);
    fail_count_o++;
  endtask

  always @(posedge clk_i) begin
    log2_result_t want;
    if (rst_ni) begin
      if (valid_o) begin
        if (expected_logs.size() == 0) begin
          report_mismatch("unexpected result", result_bits_o, 0);
        end else begin
          want = expected_logs.pop_front();
          if (result_bits_o !== want.bits)
            report_mismatch("result_bits", result_bits_o, want.bits);
          if (status_o !== want.st)
            report_mismatch("status", 32'(status_o), 32'(want.st));
        end
      end
      if (start_i && !busy_o) expected_logs.push_back(predict_log2(operand_bits_i));
    end
  end

endmodule

// ===== dv/float_binary_logarithm_test.sv =====
// Testbench top for the single-precision log2 block: drives requests and
// gives the verdict. Depends on flog2_pkg, float_binary_logarithm and float_binary_logarithm_checker.
`timescale 1ns / 100ps
module float_binary_logarithm_test;

  localparam int NUM_RANDOM = 640;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 2 * flog2_pkg::FRAC_BITS + 20;

  logic        clk_i = 0;
  logic        rst_ni = 0;
  logic        start_i = 0;
  logic        busy_o;
  logic [31:0] operand_bits_i = 0;
  logic        valid_o;
  logic [31:0] result_bits_o;
  logic [1:0]  status_o;
  int          fail_count;
  int          pending;
  int          idle_cycles = 0;

  float_binary_logarithm dut (.*);

  float_binary_logarithm_checker checker_i (
    .clk_i, .rst_ni, .start_i, .busy_o, .operand_bits_i, .valid_o,
    .result_bits_o, .status_o, .fail_count_o(fail_count), .pending_o(pending)
  );

  initial forever #4 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if ((start_i && !busy_o) || valid_o) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  task automatic send_request(logic [31:0] bits);
    start_i <= 1'b1;
    operand_bits_i <= bits;
    do @(posedge clk_i); while (busy_o);
  endtask

  task automatic idle_burst();
    start_i <= 1'b0;
    operand_bits_i <= $urandom;
    repeat ($urandom_range(1, 12)) @(posedge clk_i);
  endtask

  function automatic logic [31:0] random_operand();
    logic [31:0] x;
    x = $urandom;
    case ($urandom_range(0, 9))
      0: x[30:23] = 8'h00;
      1: x[30:23] = 8'hFF;
      2: x[30:23] = 8'($urandom_range(8'h7C, 8'h82));
      3: x = {1'b0, 8'h7F, 23'($urandom_range(0, 15))};
      4: x = {1'b0, 8'h7E, 23'h7FFFFF - 23'($urandom_range(0, 15))};
      default: x[31] = ($urandom_range(0, 4) == 0);
    endcase
    return x;
  endfunction

  logic [31:0] directed_ops[] = '{
    32'h00000000, 32'h80000000, 32'h7F800000, 32'hFF800000, 32'h7FC00000,
    32'h7F800001, 32'hFFFFFFFF, 32'h3F800000, 32'h40000000, 32'h402DF854,
    32'h40490FDB, 32'h40C90FDB, 32'h00000001, 32'h007FFFFF, 32'h00800000,
    32'h7F7FFFFF, 32'h3F7FFFFF, 32'h3F800001, 32'hBF800000, 32'hBF7FFFFF,
    32'h40490FDA, 32'h3F000000, 32'h55555555, 32'h2AAAAAAA
  };

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (directed_ops[i]) begin
      send_request(directed_ops[i]);
      if ($urandom_range(0, 3) == 0) idle_burst();
    end
    for (int i = 0; i < NUM_RANDOM; i++) begin
      send_request(random_operand());
      if (i < NUM_RANDOM - 100 && $urandom_range(0, 5) == 0) idle_burst();
    end
    start_i <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
